/* src/ipe_pkg.sv */
// Shared types for the insertion permutation enumerator.
`default_nettype none
package ipe_pkg;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUILD,
		ST_EMIT
	} ipe_state_t;

	// Per-cycle command to the row of permutation cells.
	typedef struct packed {
		logic ins;   // insert the current value, shifting the tail right
		logic emit;  // shift the row left by one toward the output
	} ipe_cell_ctl_t;

	// Reset value of the length register.
	localparam logic [3:0] PERM_LENGTH_RESET = 4'd4;

endpackage
`default_nettype wire

/* src/insertion_permutation_enumerator_top.sv */
// Top level of the insertion permutation enumerator.
`default_nettype none
// Each accepted request transaction yields n result transactions, one per
// element of the current permutation of 1..n (n = perm_length, 0 read as 1,
// values above MAX_LEN read as MAX_LEN). A request first builds the
// permutation in a row of MAX_LEN cells, one insertion per cycle, then
// shifts the elements out of cell 0, holding while out_stall is high;
// in_stall holds new requests off until the last element has left; the
// build runs through the cell row. The insertion digits form a mixed-radix
// counter held in a second row of cells; it advances as the last element of
// a permutation leaves, wrapping from 1,2,..,n back to n,..,1. restart
// clears the counter before the build. perm_length is written through
// cfg_we / cfg_wdata and must only change while no request is in flight.
module insertion_permutation_enumerator_top #(
	parameter int MAX_LEN = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_we,
	input  wire  [3:0] cfg_wdata,
	// request channel
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        restart,
	// result channel
	output logic       out_valid,
	input  wire        out_stall,
	output logic [3:0] element_value,
	output logic [2:0] element_position,
	output logic       last_of_run,
	output logic       final_permutation
);
	import ipe_pkg::*;

	localparam int DW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;  // position width
	localparam int VW = $clog2(MAX_LEN + 1);                  // value / count width

	// ---------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------
	logic [3:0] perm_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= PERM_LENGTH_RESET;
		end else if (cfg_we) begin
			perm_length_q <= cfg_wdata;
		end
	end

	// Effective length: zero reads as one, saturate at MAX_LEN.
	logic [4:0]    pl_ext;
	logic [VW-1:0] len_eff;

	assign pl_ext = {1'b0, perm_length_q};

	always_comb begin
		if (pl_ext == 5'd0) begin
			len_eff = VW'(1);
		end else if (pl_ext > 5'(MAX_LEN)) begin
			len_eff = VW'(MAX_LEN);
		end else begin
			len_eff = VW'(pl_ext);
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	ipe_state_t    state_q, state_d;
	logic [VW-1:0] len_q;     // n latched for this request
	logic [DW-1:0] step_q;    // insertion step k-1 during build
	logic [DW-1:0] idx_q;     // output position during emit

	logic          in_fire;
	logic          out_fire;
	logic          build_done;
	logic          emit_done;

	assign in_fire    = in_valid & ~in_stall;
	assign out_fire   = out_valid & ~out_stall;
	assign build_done = (VW'(step_q) + VW'(1)) == len_q;
	assign emit_done  = (VW'(idx_q) + VW'(1)) == len_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_fire)                 state_d = ST_BUILD;
			ST_BUILD: if (build_done)              state_d = ST_EMIT;
			ST_EMIT:  if (out_fire && emit_done)   state_d = ST_IDLE;
			default:                               state_d = ST_IDLE;
		endcase
	end

	ipe_cell_ctl_t cell_ctl;
	logic          digit_clear;
	logic          digit_adv;

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		out_valid     = (state_q == ST_EMIT);
		cell_ctl.ins  = (state_q == ST_BUILD);
		cell_ctl.emit = out_fire;
		digit_clear   = in_fire & restart;
		digit_adv     = out_fire & emit_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= VW'(1);
			step_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				len_q  <= len_eff;
				step_q <= '0;
				idx_q  <= '0;
			end else if (state_q == ST_BUILD) begin
				step_q <= step_q + DW'(1);
			end else if (out_fire) begin
				idx_q <= idx_q + DW'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Digit row: mixed-radix counter, carry runs from d_n down to d_1
	// ---------------------------------------------------------------
	logic [DW-1:0] digit_w [MAX_LEN];
	logic [MAX_LEN:0] carry_w;

	assign carry_w[MAX_LEN] = 1'b1;

	for (genvar g = 0; g < MAX_LEN; g++) begin : g_digit
		ipe_digit_cell #(
			.K  (g + 1),
			.DW (DW),
			.VW (VW)
		) u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.clear     (digit_clear),
			.adv       (digit_adv),
			.len       (len_q),
			.carry_in  (carry_w[g+1]),
			.carry_out (carry_w[g]),
			.digit     (digit_w[g])
		);
	end

	// ---------------------------------------------------------------
	// Permutation row
	// ---------------------------------------------------------------
	logic [DW-1:0] ins_digit;
	logic [DW-1:0] ins_pos;
	logic [VW-1:0] ins_val;

	assign ins_digit = digit_w[step_q];
	assign ins_pos   = (ins_digit > step_q) ? step_q : ins_digit;
	assign ins_val   = VW'(step_q) + VW'(1);

	logic [VW-1:0] val_w   [MAX_LEN];
	logic [VW-1:0] left_w  [MAX_LEN];
	logic [VW-1:0] right_w [MAX_LEN];

	for (genvar g = 0; g < MAX_LEN; g++) begin : g_perm
		if (g == 0) begin : g_first
			assign left_w[g] = '0;
		end else begin : g_mid_l
			assign left_w[g] = val_w[g-1];
		end
		if (g == MAX_LEN - 1) begin : g_last
			assign right_w[g] = '0;
		end else begin : g_mid_r
			assign right_w[g] = val_w[g+1];
		end

		ipe_perm_cell #(
			.IDX (g),
			.DW  (DW),
			.VW  (VW)
		) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.ins_pos   (ins_pos),
			.ins_len   (step_q),
			.ins_val   (ins_val),
			.left_val  (left_w[g]),
			.right_val (right_w[g]),
			.val       (val_w[g])
		);
	end

	// ---------------------------------------------------------------
	// Result fields come straight off cell 0; they hold while stalled.
	// Digits only move on the last result, so the carry out of d_1 is
	// the final-permutation flag for every element.
	// ---------------------------------------------------------------
	assign element_value     = 4'(val_w[0]);
	assign element_position  = 3'(idx_q);
	assign last_of_run       = emit_done;
	assign final_permutation = carry_w[0];

endmodule
`default_nettype wire

/* src/ipe_perm_cell.sv */
// One slot of the working permutation: insertion shift and output shift.
`default_nettype none
module ipe_perm_cell #(
	parameter int IDX = 0,
	parameter int DW  = 3,
	parameter int VW  = 4
) (
	input  wire                   clk,
	input  ipe_pkg::ipe_cell_ctl_t ctl,
	input  wire  [DW-1:0]         ins_pos,
	input  wire  [DW-1:0]         ins_len,
	input  wire  [VW-1:0]         ins_val,
	input  wire  [VW-1:0]         left_val,
	input  wire  [VW-1:0]         right_val,
	output logic [VW-1:0]         val
);
	import ipe_pkg::*;

	localparam logic [DW-1:0] MY_POS = DW'(IDX);

	logic [VW-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_POS == ins_pos) begin
				val_q <= ins_val;
			end else if (MY_POS > ins_pos && MY_POS <= ins_len) begin
				val_q <= left_val;
			end
		end else if (ctl.emit) begin
			val_q <= right_val;
		end
	end

	assign val = val_q;

endmodule
`default_nettype wire

/* src/ipe_digit_cell.sv */
// One insertion digit d_k of the mixed-radix counter (radix k).
`default_nettype none
module ipe_digit_cell #(
	parameter int K  = 1,
	parameter int DW = 3,
	parameter int VW = 4
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           clear,
	input  wire           adv,
	input  wire  [VW-1:0] len,
	input  wire           carry_in,
	output logic          carry_out,
	output logic [DW-1:0] digit
);
	localparam logic [DW-1:0] TOP   = DW'(K - 1);
	localparam logic [VW-1:0] MY_K  = VW'(K);

	logic [DW-1:0] digit_q;
	logic          active;
	logic          at_top;

	assign active    = (MY_K <= len);
	assign at_top    = (digit_q == TOP);
	// carry: every active digit from here upward sits at its top value
	assign carry_out = carry_in & (~active | at_top);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (clear) begin
			digit_q <= '0;
		end else if (adv && active && carry_in) begin
			digit_q <= at_top ? '0 : digit_q + DW'(1);
		end
	end

	assign digit = digit_q;

endmodule
`default_nettype wire
